@@ sv/sleep_wakeup_priority_scheduler_unit_defines.svh @@
// assertion macros for the sleep/wakeup scheduler checker
// used only by the checker file, no other dependencies
`ifndef SLEEP_WAKEUP_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define SLEEP_WAKEUP_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define SWPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/swps_pkg.sv @@
// shared types and constants of the sleep/wakeup priority scheduler
// no dependencies
package swps_pkg;

  localparam int TABLE_SIZE_DEF   = 64;
  localparam int CHANNEL_BITS_DEF = 16;

  // operation codes
  localparam logic [2:0] OP_SLEEP        = 3'd0;
  localparam logic [2:0] OP_WAKEUP       = 3'd1;
  localparam logic [2:0] OP_SET_PRIORITY = 3'd2;
  localparam logic [2:0] OP_ENQUEUE      = 3'd3;
  localparam logic [2:0] OP_DISPATCH     = 3'd4;
  localparam logic [2:0] OP_SET_ENTRY    = 3'd5;

  // process status codes
  localparam logic [2:0] ST_FREE   = 3'd0;
  localparam logic [2:0] ST_SLEEP  = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_ZOMBIE = 3'd4;

  // fault codes
  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_DEAD   = 2'd1;
  localparam logic [1:0] FAULT_QUEUED = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_BIAS   = 2'd2;

  localparam logic [6:0] THRESH_RST = 7'd25;
  localparam logic [6:0] BASE_RST   = 7'd50;
  localparam logic [5:0] BIAS_RST   = 6'd20;
  localparam logic [6:0] PRIO_MAX   = 7'd127;
  localparam logic [7:0] BEST_INIT  = 8'd128;

  // source of the process table read address
  typedef enum logic [1:0] {
    SRC_P   = 2'd0,
    SRC_IDX = 2'd1,
    SRC_RO  = 2'd2,
    SRC_SEL = 2'd3
  } ent_src_t;

  typedef struct packed {
    logic     load;
    logic     ent_rd;
    ent_src_t ent_src;
    logic     ent_apply;
    logic     wk_apply;
    logic     ds_rd;
    logic     q_latch;
    logic     ds_eval;
    logic     clr_queued;
    logic     idx_inc;
    logic     sh_init;
    logic     sh_rd;
    logic     sh_wr;
    logic     push_wr;
    logic     rm_init;
    logic     rm_rd;
    logic     rm_wr;
    logic     rm_done;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ok;
    logic       chan_zero;
    logic       push_now;
    logic       i_last;
    logic       i_end;
    logic       k_zero;
    logic       rm_last;
    logic       have;
    logic       out_free;
  } sts_t;

endpackage

@@ sv/swps_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module swps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/swps_ctrl.sv @@
// sequencing state machine of the scheduler
// depends on swps_pkg
module swps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  swps_pkg::sts_t sts,
  output swps_pkg::cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DEC     = 18'h00002,
    S_ENT_RD  = 18'h00004,
    S_ENT_OP  = 18'h00008,
    S_WK_RD   = 18'h00010,
    S_WK_CHK  = 18'h00020,
    S_SH_RD   = 18'h00040,
    S_SH_WR   = 18'h00080,
    S_PUSH_WR = 18'h00100,
    S_DS_RO   = 18'h00200,
    S_DS_ENT  = 18'h00400,
    S_DS_CHK  = 18'h00800,
    S_DS_END  = 18'h01000,
    S_RM_RD   = 18'h02000,
    S_RM_WR   = 18'h04000,
    S_RM_DONE = 18'h08000,
    S_DS_CLR  = 18'h10000,
    S_FIN     = 18'h20000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.ent_src = swps_pkg::SRC_P;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op) inside
          swps_pkg::OP_SLEEP, swps_pkg::OP_SET_PRIORITY,
          swps_pkg::OP_ENQUEUE, swps_pkg::OP_SET_ENTRY: begin
            state_next = sts.ok ? S_ENT_RD : S_FIN;
          end
          swps_pkg::OP_WAKEUP: begin
            state_next = sts.chan_zero ? S_FIN : S_WK_RD;
          end
          swps_pkg::OP_DISPATCH: begin
            state_next = S_DS_RO;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_ENT_RD: begin
        cmd.ent_rd  = 1'b1;
        cmd.ent_src = swps_pkg::SRC_P;
        state_next  = S_ENT_OP;
      end
      S_ENT_OP: begin
        cmd.ent_apply = 1'b1;
        if (sts.op == swps_pkg::OP_ENQUEUE && sts.push_now) begin
          cmd.sh_init = 1'b1;
          state_next  = S_SH_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_WK_RD: begin
        cmd.ent_rd  = 1'b1;
        cmd.ent_src = swps_pkg::SRC_IDX;
        state_next  = S_WK_CHK;
      end
      S_WK_CHK: begin
        cmd.wk_apply = 1'b1;
        if (sts.push_now) begin
          cmd.sh_init = 1'b1;
          state_next  = S_SH_RD;
        end else if (sts.i_last) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_WK_RD;
        end
      end
      S_SH_RD: begin
        if (sts.k_zero) begin
          state_next = S_PUSH_WR;
        end else begin
          cmd.sh_rd  = 1'b1;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = S_SH_RD;
      end
      S_PUSH_WR: begin
        cmd.push_wr = 1'b1;
        if (sts.op == swps_pkg::OP_WAKEUP && !sts.i_last) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_WK_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DS_RO: begin
        if (sts.i_end) begin
          state_next = S_DS_END;
        end else begin
          cmd.ds_rd  = 1'b1;
          state_next = S_DS_ENT;
        end
      end
      S_DS_ENT: begin
        cmd.ent_rd  = 1'b1;
        cmd.ent_src = swps_pkg::SRC_RO;
        cmd.q_latch = 1'b1;
        state_next  = S_DS_CHK;
      end
      S_DS_CHK: begin
        cmd.ds_eval = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_DS_RO;
      end
      S_DS_END: begin
        if (sts.have) begin
          cmd.rm_init = 1'b1;
          state_next  = S_RM_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RM_RD: begin
        if (sts.rm_last) begin
          state_next = S_RM_DONE;
        end else begin
          cmd.rm_rd  = 1'b1;
          state_next = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd.rm_wr  = 1'b1;
        state_next = S_RM_RD;
      end
      S_RM_DONE: begin
        cmd.rm_done = 1'b1;
        cmd.ent_rd  = 1'b1;
        cmd.ent_src = swps_pkg::SRC_SEL;
        state_next  = S_DS_CLR;
      end
      S_DS_CLR: begin
        cmd.clr_queued = 1'b1;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/swps_dpath.sv @@
// datapath: config registers, process table, run list, result register
// depends on swps_pkg and swps_ram
module swps_dpath #(
  parameter int TABLE_SIZE   = swps_pkg::TABLE_SIZE_DEF,
  parameter int CHANNEL_BITS = swps_pkg::CHANNEL_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  input  logic [2:0]     operation,
  input  logic [5:0]     process,
  input  logic [15:0]    channel,
  input  logic [6:0]     sleep_priority,
  input  logic           signal_pending,
  input  logic [7:0]     cpu_usage,
  input  logic [5:0]     nice_value,
  input  logic [2:0]     entry_status,
  input  logic           entry_loaded,
  output logic           result_valid,
  input  logic           result_ready,
  output logic           found,
  output logic [5:0]     selected_process,
  output logic [6:0]     computed_priority,
  output logic           need_resched,
  output logic           sleep_aborted,
  output logic [1:0]     fault,
  input  swps_pkg::cmd_t cmd,
  output swps_pkg::sts_t sts
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int CB = CHANNEL_BITS;
  localparam int RW = CB + 18;

  // config
  logic [6:0] thresh, base;
  logic [5:0] bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= swps_pkg::THRESH_RST;
      base   <= swps_pkg::BASE_RST;
      bias   <= swps_pkg::BIAS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        swps_pkg::REG_THRESH: thresh <= pwdata[6:0];
        swps_pkg::REG_BASE:   base   <= pwdata[6:0];
        swps_pkg::REG_BIAS:   bias   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      swps_pkg::REG_THRESH: prdata = {25'd0, thresh};
      swps_pkg::REG_BASE:   prdata = {25'd0, base};
      swps_pkg::REG_BIAS:   prdata = {26'd0, bias};
      default:              prdata = '0;
    endcase
  end

  // captured item
  logic [2:0]    op_q;
  logic [IW-1:0] p_q;
  logic          ok_q;
  logic [CB-1:0] chan_q;
  logic [6:0]    spri_q;
  logic          sig_q;
  logic [7:0]    cpu_q;
  logic [5:0]    nice_q;
  logic [2:0]    est_q;
  logic          eld_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      p_q    <= IW'(process);
      ok_q   <= (32'(process) < TABLE_SIZE);
      chan_q <= CB'(channel);
      spri_q <= sleep_priority;
      sig_q  <= signal_pending;
      cpu_q  <= cpu_usage;
      nice_q <= nice_value;
      est_q  <= entry_status;
      eld_q  <= entry_loaded;
    end
  end

  // scheduler state
  logic [CW-1:0] count, idx, k;
  logic [6:0]    cur_pri;
  logic          resched;
  logic [7:0]    best;
  logic [IW-1:0] pos, sel, q;
  logic          have;
  logic [TABLE_SIZE-1:0] ent_valid;

  // process table
  logic          ent_we, ent_re, ent_vld_q;
  logic [IW-1:0] ent_waddr, ent_raddr;
  logic [RW-1:0] ent_wdata, ent_raw, ent_rec;

  // run list
  logic          ro_we, ro_re;
  logic [IW-1:0] ro_waddr, ro_raddr, ro_wdata, ro_rdata;

  swps_ram #(.WIDTH(RW), .DEPTH(TABLE_SIZE)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_raw)
  );

  swps_ram #(.WIDTH(IW), .DEPTH(TABLE_SIZE)) u_ro (
    .clk(clk), .we(ro_we), .waddr(ro_waddr), .wdata(ro_wdata),
    .re(ro_re), .raddr(ro_raddr), .rdata(ro_rdata)
  );

  // never-written entries read as the reset record
  assign ent_rec = ent_vld_q ? ent_raw : '0;

  logic [2:0]    e_state;
  logic          e_res, e_q;
  logic [CB-1:0] e_chan;
  logic [6:0]    e_prio;
  logic [5:0]    e_nice;

  assign e_state = ent_rec[RW-1 -: 3];
  assign e_res   = ent_rec[RW-4];
  assign e_chan  = ent_rec[RW-5 -: CB];
  assign e_prio  = ent_rec[13:7];
  assign e_nice  = ent_rec[6:1];
  assign e_q     = ent_rec[0];

  always_comb begin
    unique case (cmd.ent_src)
      swps_pkg::SRC_P:   ent_raddr = p_q;
      swps_pkg::SRC_IDX: ent_raddr = IW'(idx);
      swps_pkg::SRC_RO:  ent_raddr = ro_rdata;
      swps_pkg::SRC_SEL: ent_raddr = sel;
      default:           ent_raddr = p_q;
    endcase
  end
  assign ent_re = cmd.ent_rd;

  // combinational decisions
  logic          not_full, wk_match, push_now, abort;
  logic [8:0]    pri_sum, pri_diff;
  logic [6:0]    cpri;

  assign not_full = (count < CW'(TABLE_SIZE));
  assign wk_match = (e_chan == chan_q) && (e_state != swps_pkg::ST_ZOMBIE);
  assign abort    = (spri_q > thresh) && sig_q;

  always_comb begin
    if (op_q == swps_pkg::OP_WAKEUP) begin
      push_now = wk_match && (e_state != swps_pkg::ST_FREE) && !e_q && not_full;
    end else begin
      push_now = !e_q && not_full;
    end
  end

  assign pri_sum  = 9'(cpu_q[7:4]) + 9'(base) + 9'(e_nice);
  assign pri_diff = pri_sum - 9'(bias);
  always_comb begin
    if (pri_sum < 9'(bias)) begin
      cpri = '0;
    end else if (pri_diff > 9'(swps_pkg::PRIO_MAX)) begin
      cpri = swps_pkg::PRIO_MAX;
    end else begin
      cpri = pri_diff[6:0];
    end
  end

  // table write
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = p_q;
    ent_wdata = ent_rec;
    if (cmd.ent_apply) begin
      ent_waddr = p_q;
      case (op_q)
        swps_pkg::OP_SLEEP: begin
          ent_we    = 1'b1;
          ent_wdata = {abort ? swps_pkg::ST_RUN : swps_pkg::ST_SLEEP, e_res,
                       abort ? CB'(0) : chan_q, spri_q, e_nice, e_q};
        end
        swps_pkg::OP_SET_PRIORITY: begin
          ent_we    = 1'b1;
          ent_wdata = {e_state, e_res, e_chan, cpri, e_nice, e_q};
        end
        swps_pkg::OP_ENQUEUE: begin
          ent_we    = push_now;
          ent_wdata = {e_state, e_res, e_chan, e_prio, e_nice, 1'b1};
        end
        swps_pkg::OP_SET_ENTRY: begin
          ent_we    = 1'b1;
          ent_wdata = {est_q, eld_q, e_chan, e_prio, nice_q, e_q};
        end
        default: ent_we = 1'b0;
      endcase
    end else if (cmd.wk_apply) begin
      ent_waddr = IW'(idx);
      ent_we    = wk_match && (e_state != swps_pkg::ST_FREE);
      ent_wdata = {swps_pkg::ST_RUN, e_res, CB'(0), e_prio, e_nice, e_q | push_now};
    end else if (cmd.clr_queued) begin
      ent_waddr = sel;
      ent_we    = 1'b1;
      ent_wdata = {e_state, e_res, e_chan, e_prio, e_nice, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      ent_vld_q <= ent_valid[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (ent_we) begin
      ent_valid[ent_waddr] <= 1'b1;
    end
  end

  // run list access
  assign ro_re = cmd.sh_rd | cmd.rm_rd | cmd.ds_rd;
  always_comb begin
    if (cmd.sh_rd) begin
      ro_raddr = IW'(k - 1'b1);
    end else if (cmd.rm_rd) begin
      ro_raddr = IW'(k + 1'b1);
    end else begin
      ro_raddr = IW'(idx);
    end
  end
  assign ro_we    = cmd.sh_wr | cmd.rm_wr | cmd.push_wr;
  assign ro_waddr = cmd.push_wr ? '0 : IW'(k);
  assign ro_wdata = cmd.push_wr ? ((op_q == swps_pkg::OP_WAKEUP) ? IW'(idx) : p_q)
                                : ro_rdata;

  // results in progress
  logic       r_found, r_abort;
  logic [5:0] r_sel;
  logic [6:0] r_cpri;
  logic [1:0] r_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cur_pri <= '0;
      resched <= 1'b0;
    end else begin
      if (cmd.load && operation == swps_pkg::OP_DISPATCH) begin
        resched <= 1'b0;
      end
      if (cmd.ent_apply && op_q == swps_pkg::OP_SET_PRIORITY && cpri < cur_pri) begin
        resched <= 1'b1;
      end
      if (cmd.wk_apply && wk_match && e_state != swps_pkg::ST_FREE &&
          e_prio < cur_pri) begin
        resched <= 1'b1;
      end
      if (cmd.push_wr) begin
        count <= count + 1'b1;
      end
      if (cmd.rm_done) begin
        count <= count - 1'b1;
      end
      if (cmd.clr_queued) begin
        cur_pri <= best[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx     <= '0;
      best    <= swps_pkg::BEST_INIT;
      have    <= 1'b0;
      r_found <= 1'b0;
      r_abort <= 1'b0;
      r_sel   <= '0;
      r_cpri  <= '0;
      r_fault <= swps_pkg::FAULT_NONE;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.sh_init) begin
        k <= count;
      end else if (cmd.rm_init) begin
        k <= CW'(pos);
      end else if (cmd.sh_wr) begin
        k <= k - 1'b1;
      end else if (cmd.rm_wr) begin
        k <= k + 1'b1;
      end
      if (cmd.q_latch) begin
        q <= ro_rdata;
      end
      if (cmd.ds_eval && e_state == swps_pkg::ST_RUN && e_res && {1'b0, e_prio} < best) begin
        best <= {1'b0, e_prio};
        pos  <= IW'(idx);
        sel  <= q;
        have <= 1'b1;
      end
      if (cmd.ent_apply) begin
        case (op_q)
          swps_pkg::OP_SLEEP:        r_abort <= abort;
          swps_pkg::OP_SET_PRIORITY: r_cpri  <= cpri;
          swps_pkg::OP_ENQUEUE: begin
            if (!push_now) begin
              r_fault <= swps_pkg::FAULT_QUEUED;
            end
          end
          default: ;
        endcase
      end
      if (cmd.wk_apply && wk_match) begin
        if (e_state == swps_pkg::ST_FREE) begin
          r_fault <= swps_pkg::FAULT_DEAD;
        end else if (!push_now && r_fault == swps_pkg::FAULT_NONE) begin
          r_fault <= swps_pkg::FAULT_QUEUED;
        end
      end
      if (cmd.clr_queued) begin
        r_found <= 1'b1;
        r_sel   <= 6'(sel);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found             <= r_found;
      selected_process  <= r_sel;
      computed_priority <= r_cpri;
      need_resched      <= resched;
      sleep_aborted     <= r_abort;
      fault             <= r_fault;
    end
  end

  always_comb begin
    sts           = '0;
    sts.op        = op_q;
    sts.ok        = ok_q;
    sts.chan_zero = (chan_q == '0);
    sts.push_now  = push_now;
    sts.i_last    = (idx == CW'(TABLE_SIZE - 1));
    sts.i_end     = (idx == count);
    sts.k_zero    = (k == '0);
    sts.rm_last   = ((CW + 1)'(k) + 1'b1) >= (CW + 1)'(count);
    sts.have      = have;
    sts.out_free  = !result_valid || result_ready;
  end

endmodule

@@ sv/sleep_wakeup_priority_scheduler_unit.sv @@
// Sleep/wakeup priority scheduler: a process table and a LIFO run list, one operation
// per accepted item, one result per item. Items are handled one at a time; the block
// takes a new item while the previous result waits in the output register. Sleep,
// set_priority and set_entry read and rewrite one table entry; a rejected enqueue
// only reads it. Enqueue moves the run list through its simple dual-port memory.
// Wakeup reads every table entry and moves the run list for each entry it queues.
// Dispatch reads each queued entry, then moves the entries after the chosen one down
// over it. Configuration goes through the APB port at byte addresses 0, 4 and 8.
// depends on swps_pkg, swps_ctrl, swps_dpath
module sleep_wakeup_priority_scheduler_unit #(
  parameter int TABLE_SIZE   = swps_pkg::TABLE_SIZE_DEF,
  parameter int CHANNEL_BITS = swps_pkg::CHANNEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  operation,
  input  logic [5:0]  process,
  input  logic [15:0] channel,
  input  logic [6:0]  sleep_priority,
  input  logic        signal_pending,
  input  logic [7:0]  cpu_usage,
  input  logic [5:0]  nice_value,
  input  logic [2:0]  entry_status,
  input  logic        entry_loaded,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        found,
  output logic [5:0]  selected_process,
  output logic [6:0]  computed_priority,
  output logic        need_resched,
  output logic        sleep_aborted,
  output logic [1:0]  fault
);

  swps_pkg::cmd_t cmd;
  swps_pkg::sts_t sts;

  assign pready = 1'b1;

  swps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .sts(sts), .cmd(cmd)
  );

  swps_dpath #(.TABLE_SIZE(TABLE_SIZE), .CHANNEL_BITS(CHANNEL_BITS)) u_dpath (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .operation(operation), .process(process), .channel(channel),
    .sleep_priority(sleep_priority), .signal_pending(signal_pending),
    .cpu_usage(cpu_usage), .nice_value(nice_value), .entry_status(entry_status),
    .entry_loaded(entry_loaded),
    .result_valid(result_valid), .result_ready(result_ready),
    .found(found), .selected_process(selected_process),
    .computed_priority(computed_priority), .need_resched(need_resched),
    .sleep_aborted(sleep_aborted), .fault(fault),
    .cmd(cmd), .sts(sts)
  );

endmodule

@@ sv/swps_checker.sv @@
// port-level checks of the scheduler, bound to the top level
// depends on sleep_wakeup_priority_scheduler_unit_defines.svh
`include "sleep_wakeup_priority_scheduler_unit_defines.svh"

module swps_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic       found,
  input logic [5:0] selected_process,
  input logic       need_resched,
  input logic       sleep_aborted
);

  // one item in flight at a time
  `SWPS_ASSERT_NXT(a_one_item, item_valid && item_ready, !item_ready, "item taken while busy")
  // dispatch always clears the reschedule flag
  `SWPS_ASSERT_IMP(a_found_resched, result_valid && found, !need_resched, "resched after dispatch")
  `SWPS_ASSERT_IMP(a_sel_zero, result_valid && !found, selected_process == 6'd0, "stray selection")
  // a stalled result holds
  `SWPS_ASSERT_NXT(a_hold, result_valid && !result_ready,
                   result_valid && $stable(found) && $stable(sleep_aborted), "result dropped")

endmodule

bind sleep_wakeup_priority_scheduler_unit swps_checker u_swps_checker (.*);

@@ test/tb_sleep_wakeup_priority_scheduler_unit.sv @@
// testbench for the sleep/wakeup priority scheduler: random and directed operations,
// results checked against a behavioral model of the process table and run list
// depends on swps_pkg and sleep_wakeup_priority_scheduler_unit
`timescale 1ns / 1ps

class sched_scoreboard;
  // model state
  logic [2:0]  ent_state [64];
  logic        ent_res   [64];
  logic [15:0] ent_chan  [64];
  logic [6:0]  ent_prio  [64];
  logic [5:0]  ent_nice  [64];
  logic        ent_q     [64];
  logic [5:0]  run_list [$];
  logic [6:0]  cur_prio;
  logic        resched;
  logic [6:0]  thresh, base;
  logic [5:0]  bias;
  logic [21:0] pending [$];  // found,sel,cpri,resched,aborted,0,fault
  int errors;

  function new();
    for (int i = 0; i < 64; i++) begin
      ent_state[i] = swps_pkg::ST_FREE; ent_res[i] = 0; ent_chan[i] = 0;
      ent_prio[i] = 0; ent_nice[i] = 0; ent_q[i] = 0;
    end
    cur_prio = 0; resched = 0; errors = 0;
    thresh = swps_pkg::THRESH_RST; base = swps_pkg::BASE_RST; bias = swps_pkg::BIAS_RST;
  endfunction

  function logic [1:0] push_run(int p);
    if (ent_q[p] || run_list.size() >= 64) return swps_pkg::FAULT_QUEUED;
    run_list.push_front(p[5:0]);
    ent_q[p] = 1;
    return swps_pkg::FAULT_NONE;
  endfunction

  function void note_item(logic [2:0] op, logic [5:0] p, logic [15:0] ch, logic [6:0] sp,
                          logic sig, logic [7:0] cpu, logic [5:0] nv, logic [2:0] est,
                          logic eld);
    logic fnd, abt;
    logic [5:0] sel;
    logic [6:0] cpri;
    logic [1:0] flt, f;
    int v, best, pos;
    fnd = 0; abt = 0; sel = 0; cpri = 0; flt = swps_pkg::FAULT_NONE;
    case (op)
      swps_pkg::OP_SLEEP: begin
        ent_state[p] = swps_pkg::ST_SLEEP; ent_chan[p] = ch; ent_prio[p] = sp;
        if (sp > thresh && sig) begin
          ent_chan[p] = 0; ent_state[p] = swps_pkg::ST_RUN; abt = 1;
        end
      end
      swps_pkg::OP_WAKEUP: if (ch != 0) begin
        for (int i = 0; i < 64; i++) begin
          if (ent_chan[i] != ch || ent_state[i] == swps_pkg::ST_ZOMBIE) continue;
          if (ent_state[i] == swps_pkg::ST_FREE) begin
            flt = swps_pkg::FAULT_DEAD;
            continue;
          end
          ent_chan[i] = 0; ent_state[i] = swps_pkg::ST_RUN;
          f = push_run(i);
          if (ent_prio[i] < cur_prio) resched = 1;
          if (f != swps_pkg::FAULT_NONE && flt == swps_pkg::FAULT_NONE) flt = f;
        end
      end
      swps_pkg::OP_SET_PRIORITY: begin
        v = cpu / 16 + base + ent_nice[p] - bias;
        if (v > 127) v = 127;
        if (v < 0) v = 0;
        cpri = v[6:0];
        if (cpri < cur_prio) resched = 1;
        ent_prio[p] = cpri;
      end
      swps_pkg::OP_ENQUEUE: flt = push_run(p);
      swps_pkg::OP_DISPATCH: begin
        best = 128; pos = -1; resched = 0;
        foreach (run_list[i])
          if (ent_state[run_list[i]] == swps_pkg::ST_RUN && ent_res[run_list[i]]
              && ent_prio[run_list[i]] < best) begin
            best = ent_prio[run_list[i]]; pos = i;
          end
        if (pos >= 0) begin
          sel = run_list[pos]; run_list.delete(pos);
          ent_q[sel] = 0; cur_prio = best[6:0]; fnd = 1;
        end
      end
      swps_pkg::OP_SET_ENTRY: begin
        ent_state[p] = est; ent_res[p] = eld; ent_nice[p] = nv;
      end
      default: ;
    endcase
    pending.push_back({fnd, sel, cpri, resched, abt, 1'b0, flt});
  endfunction

  task check_result(logic [21:0] got);
    logic [21:0] exp_r;
    if (pending.size() == 0) begin
      report("result with nothing expected", got, 0);
      return;
    end
    exp_r = pending.pop_front();
    if (got[18] != exp_r[18]) report("found", got, exp_r);
    if (got[17:12] != exp_r[17:12]) report("selected_process", got, exp_r);
    if (got[11:5] != exp_r[11:5]) report("computed_priority", got, exp_r);
    if (got[4:3] != exp_r[4:3]) report("need_resched/sleep_aborted", got, exp_r);
    if (got[1:0] != exp_r[1:0]) report("fault", got, exp_r);
  endtask

  task report(string what, logic [21:0] got, logic [21:0] want);
    errors++;
    if (errors < 50) $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask
endclass

module tb_sleep_wakeup_priority_scheduler_unit;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic item_valid = 0, item_ready;
  logic [2:0] operation = 0;
  logic [5:0] process = 0;
  logic [15:0] channel = 0;
  logic [6:0] sleep_priority = 0;
  logic signal_pending = 0;
  logic [7:0] cpu_usage = 0;
  logic [5:0] nice_value = 0;
  logic [2:0] entry_status = 0;
  logic entry_loaded = 0;
  logic result_valid, result_ready = 0;
  logic found, need_resched, sleep_aborted;
  logic [5:0] selected_process;
  logic [6:0] computed_priority;
  logic [1:0] fault;

  sched_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0, random_stall = 1;

  sleep_wakeup_priority_scheduler_unit i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready)
        sb.check_result({found, selected_process, computed_priority, need_resched,
                         sleep_aborted, 1'b0, fault});
      if (hold_off) result_ready <= 0;
      else if (random_stall) result_ready <= ($urandom_range(0, 3) != 0);
      else result_ready <= 1;
      if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 200000) begin
        $display("tb_sleep_wakeup_priority_scheduler_unit: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      swps_pkg::REG_THRESH: sb.thresh = val[6:0];
      swps_pkg::REG_BASE:   sb.base = val[6:0];
      default:              sb.bias = val[5:0];
    endcase
  endtask

  task automatic send_item(logic [2:0] op, logic [5:0] p, logic [15:0] ch, logic [6:0] sp,
                           logic sig, logic [7:0] cpu, logic [5:0] nv, logic [2:0] est,
                           logic eld);
    operation <= op; process <= p; channel <= ch; sleep_priority <= sp;
    signal_pending <= sig; cpu_usage <= cpu; nice_value <= nv; entry_status <= est;
    entry_loaded <= eld; item_valid <= 1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(op, p, ch, sp, sig, cpu, nv, est, eld);
  endtask

  // idle gap after a transfer; lowers valid only when a gap follows
  task automatic gap(int n);
    if (n > 0) begin
      item_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // mostly well-formed scheduling traffic over a small set of channels
  task automatic random_item();
    logic [2:0] op;
    logic [15:0] ch;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) op = swps_pkg::OP_SLEEP;
    else if (r < 35) op = swps_pkg::OP_WAKEUP;
    else if (r < 47) op = swps_pkg::OP_SET_PRIORITY;
    else if (r < 62) op = swps_pkg::OP_ENQUEUE;
    else if (r < 80) op = swps_pkg::OP_DISPATCH;
    else if (r < 97) op = swps_pkg::OP_SET_ENTRY;
    else op = 3'($urandom_range(6, 7));
    ch = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if ($urandom_range(0, 19) == 0) ch = 16'hFFFF;
    send_item(op, ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11)),
              ch, 7'($urandom), 1'($urandom), 8'($urandom), 6'($urandom_range(0, 39)),
              ($urandom_range(0, 2) == 0) ? 3'($urandom) : swps_pkg::ST_RUN,
              ($urandom_range(0, 4) != 0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: populate, sleep/abort, wakeup paths, faults, dispatch extremes
    send_item(swps_pkg::OP_SET_ENTRY, 0, 0, 0, 0, 0, 39, swps_pkg::ST_RUN, 1);
    send_item(swps_pkg::OP_SET_ENTRY, 63, 0, 0, 0, 0, 0, swps_pkg::ST_RUN, 1);
    send_item(swps_pkg::OP_SET_ENTRY, 5, 0, 0, 0, 0, 20, 3'd7, 1);
    send_item(swps_pkg::OP_SET_ENTRY, 6, 0, 0, 0, 0, 20, swps_pkg::ST_ZOMBIE, 1);
    send_item(swps_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_SET_PRIORITY, 0, 0, 0, 0, 8'hFF, 0, 0, 0);
    send_item(swps_pkg::OP_SET_PRIORITY, 63, 0, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_SLEEP, 63, 16'hFFFF, 127, 1, 0, 0, 0, 0);
    send_item(swps_pkg::OP_SLEEP, 0, 16'hFFFF, 10, 1, 0, 0, 0, 0);
    send_item(swps_pkg::OP_SLEEP, 6, 16'hFFFF, 10, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_SLEEP, 7, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_SET_ENTRY, 7, 0, 0, 0, 0, 0, swps_pkg::ST_FREE, 0);
    send_item(swps_pkg::OP_WAKEUP, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_WAKEUP, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_ENQUEUE, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_ENQUEUE, 63, 0, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_SLEEP, 0, 16'h0001, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_WAKEUP, 0, 16'h0001, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(swps_pkg::OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(3'd6, 1, 1, 1, 1, 1, 1, 1, 1);
    send_item(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // phases over register settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(swps_pkg::REG_THRESH, 0); write_reg(swps_pkg::REG_BASE, 127);
                 write_reg(swps_pkg::REG_BIAS, 0); end
        1: begin write_reg(swps_pkg::REG_THRESH, 127); write_reg(swps_pkg::REG_BASE, 0);
                 write_reg(swps_pkg::REG_BIAS, 39); end
        2: begin write_reg(swps_pkg::REG_THRESH, $urandom_range(0, 127));
                 write_reg(swps_pkg::REG_BASE, $urandom_range(0, 127));
                 write_reg(swps_pkg::REG_BIAS, $urandom_range(0, 39)); end
        default: begin write_reg(swps_pkg::REG_THRESH, 25);
                       write_reg(swps_pkg::REG_BASE, 50);
                       write_reg(swps_pkg::REG_BIAS, 20); end
      endcase
      random_stall = (ph != 3);
      if (ph == 1) fork
        begin hold_off = 1; repeat (3000) @(posedge clk); hold_off = 0; end
      join_none
      for (int n = 0; n < 150; ) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 150; b++, n++) random_item();
        if (ph != 3) gap($urandom_range(0, 6));
        if (n == 75 && ph == 2) drain();
      end
      drain();
    end

    if (sb.errors == 0)
      $display("tb_sleep_wakeup_priority_scheduler_unit: done, clean");
    else
      $display("tb_sleep_wakeup_priority_scheduler_unit: done, errors");
    $finish;
  end
endmodule
